// ----- design/mkf_pkg.sv -----
// ----------------------------------------------------------------------------
// Median and Kalman force filter package
// Shared constants, register indexes and the queue beat type.
// ----------------------------------------------------------------------------
package mkf_pkg;

  localparam int MAX_WINDOW_DEF = 16;

  localparam logic [4:0]  WINDOW_LEN_RST    = 5'd5;
  localparam logic [31:0] PROCESS_NOISE_RST = 32'd16777;
  localparam logic [31:0] MEASURE_NOISE_RST = 32'd1677722;
  localparam logic [31:0] COV_RST           = 32'd16777216;

  localparam logic [24:0] ONE_Q24  = 25'h100_0000;
  localparam int          FRAC_W   = 24;

  typedef enum logic [1:0] {
    REG_WINDOW_LEN    = 2'd0,
    REG_PROCESS_NOISE = 2'd1,
    REG_MEASURE_NOISE = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  // One median handed from the front to the back.
  typedef struct packed {
    logic        valid;
    logic [31:0] median;
  } med_beat_t;

endpackage

// ----- design/mkf_front.sv -----
// ----------------------------------------------------------------------------
// Median front end
// Holds the newest samples in a shift line and finds the median by rank scan.
// ----------------------------------------------------------------------------
module mkf_front #(
  parameter int MAX_WINDOW = mkf_pkg::MAX_WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_sample,
  input  logic [4:0]          window_len,
  input  logic                q_full,
  output mkf_pkg::med_beat_t  push
);
  import mkf_pkg::*;

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  typedef enum logic [1:0] {F_IDLE, F_SCAN, F_PUSH} fstate_t;

  fstate_t           state_r;
  logic signed [31:0] win_r  [MAX_WINDOW];
  logic signed [31:0] cand_r [MAX_WINDOW];
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  n_r;
  logic [31:0]       med_r;

  logic [CNT_W-1:0]  fill_nxt;
  logic [CNT_W-1:0]  win_eff;
  logic [CNT_W-1:0]  n_nxt;
  logic [CNT_W-1:0]  rank;
  logic [CNT_W-1:0]  less_cnt;
  logic [CNT_W:0]    le_cnt;
  logic [MAX_WINDOW-1:0] lt_vec;
  logic [MAX_WINDOW-1:0] eq_vec;
  logic              found;
  logic              accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == F_IDLE);
  assign push.valid  = (state_r == F_PUSH);
  assign push.median = med_r;

  always_comb begin
    fill_nxt = (int'(fill_r) < MAX_WINDOW) ? fill_r + 1'b1 : fill_r;
    if (window_len == 5'd0) begin
      win_eff = CNT_W'(1);
    end else if (int'(window_len) > MAX_WINDOW) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = CNT_W'(window_len);
    end
    n_nxt = (fill_nxt < win_eff) ? fill_nxt : win_eff;
  end

  // Compare the current candidate with every sample inside the window at once.
  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      lt_vec[j] = (j < int'(n_r)) && (win_r[j] < cand_r[0]);
      eq_vec[j] = (j < int'(n_r)) && (win_r[j] == cand_r[0]);
    end
    rank     = n_r >> 1;
    less_cnt = CNT_W'($countones(lt_vec));
    le_cnt   = (CNT_W+1)'($countones(lt_vec)) + (CNT_W+1)'($countones(eq_vec));
    found    = (less_cnt <= rank) && ({1'b0, rank} < le_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      fill_r  <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            win_r[0]  <= in_sample;
            cand_r[0] <= in_sample;
            for (int j = 1; j < MAX_WINDOW; j++) begin
              win_r[j]  <= win_r[j-1];
              cand_r[j] <= win_r[j-1];
            end
            fill_r  <= fill_nxt;
            n_r     <= n_nxt;
            state_r <= F_SCAN;
          end
        end
        F_SCAN: begin
          if (found) begin
            med_r   <= cand_r[0];
            state_r <= F_PUSH;
          end else begin
            // Rotate so the next newest sample becomes the candidate.
            for (int j = 0; j < MAX_WINDOW - 1; j++) begin
              cand_r[j] <= cand_r[j+1];
            end
            cand_r[MAX_WINDOW-1] <= cand_r[0];
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- design/mkf_queue.sv -----
// ----------------------------------------------------------------------------
// Median queue
// Two-entry queue of medians between the front end and the filter.
// ----------------------------------------------------------------------------
module mkf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  mkf_pkg::med_beat_t push,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output logic [31:0]        head
);
  import mkf_pkg::*;

  logic [31:0] slot_r [2];
  logic [1:0]  cnt_r;
  logic        do_push;
  logic        do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = slot_r[0];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // A push and a pop together only happen with one entry held, so the new
  // median lands straight in the head slot.
  always_ff @(posedge clk) begin
    if (do_pop) begin
      if (do_push && cnt_r == 2'd1) begin
        slot_r[1'b0] <= push.median;
      end else begin
        slot_r[1'b0] <= slot_r[1'b1];
      end
    end else if (do_push) begin
      if (cnt_r == 2'd0) begin
        slot_r[1'b0] <= push.median;
      end else begin
        slot_r[1'b1] <= push.median;
      end
    end
  end

endmodule

// ----- design/mkf_back.sv -----
// ----------------------------------------------------------------------------
// Kalman back end
// Scalar Kalman update with a bit-serial gain divider and an output register.
// ----------------------------------------------------------------------------
module mkf_back (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  logic [31:0] q_head,
  output logic        q_pop,
  input  logic [31:0] process_noise,
  input  logic [31:0] measure_noise,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data
);
  import mkf_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_MUL, B_FIN} bstate_t;

  bstate_t            state_r;
  logic               seeded_r;
  logic signed [31:0] x_r;
  logic [31:0]        cov_r;
  logic signed [31:0] m_r;
  logic [31:0]        p_r;
  logic [32:0]        den_r;
  logic [33:0]        rem_r;
  logic [24:0]        k_r;
  logic [4:0]         cnt_r;
  logic signed [58:0] prod_x_r;
  logic [56:0]        prod_p_r;
  logic               out_valid_r;
  logic [63:0]        out_data_r;

  logic [32:0]        p_sum;
  logic [31:0]        p_sat;
  logic [32:0]        den;
  logic [33:0]        rem_sh;
  logic signed [31:0] x_use;
  logic signed [32:0] diff;
  logic signed [34:0] delta;
  logic signed [35:0] xn;
  logic signed [31:0] x_fin;
  logic [56:0]        p_round;
  logic               out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == B_IDLE) && q_valid;

  always_comb begin
    p_sum  = {1'b0, cov_r} + {1'b0, process_noise};
    p_sat  = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
    den    = {1'b0, p_sat} + {1'b0, measure_noise};
    rem_sh = {rem_r[32:0], 1'b0};
    x_use  = seeded_r ? x_r : m_r;
    diff   = 33'(m_r) - 33'(x_use);
    delta  = 35'((prod_x_r + 59'sd8388608) >>> FRAC_W);
    xn     = 36'(x_r) + 36'(delta);
    if (xn > 36'sd2147483647) begin
      x_fin = 32'sh7FFF_FFFF;
    end else if (xn < -36'sd2147483648) begin
      x_fin = 32'sh8000_0000;
    end else begin
      x_fin = xn[31:0];
    end
    p_round = (prod_p_r + 57'd8388608) >> FRAC_W;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      seeded_r    <= 1'b0;
      x_r         <= '0;
      cov_r       <= COV_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == B_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            m_r   <= q_head;
            p_r   <= p_sat;
            den_r <= den;
            rem_r <= {2'b00, p_sat};
            cnt_r <= 5'd0;
            if (den == 33'd0) begin
              k_r     <= '0;
              state_r <= B_MUL;
            end else if (den == {1'b0, p_sat}) begin
              k_r     <= ONE_Q24;
              state_r <= B_MUL;
            end else begin
              k_r     <= '0;
              state_r <= B_DIV;
            end
          end
        end
        B_DIV: begin
          // One quotient bit per cycle; the remainder stays below the divisor.
          if (rem_sh >= {1'b0, den_r}) begin
            rem_r <= rem_sh - {1'b0, den_r};
            k_r   <= {k_r[23:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            k_r   <= {k_r[23:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(FRAC_W - 1)) begin
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          x_r      <= x_use;
          seeded_r <= 1'b1;
          prod_x_r <= $signed({1'b0, k_r}) * diff;
          prod_p_r <= p_r * (ONE_Q24 - k_r);
          state_r  <= B_FIN;
        end
        B_FIN: begin
          if (out_free) begin
            x_r        <= x_fin;
            cov_r      <= p_round[31:0];
            out_data_r <= {x_fin, m_r};
            state_r    <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- design/median_kalman_force_filter.sv -----
// ----------------------------------------------------------------------------
// Median and Kalman force filter
// Sliding-window median of force samples followed by a scalar Kalman filter.
// ----------------------------------------------------------------------------
// Each accepted sample passes through the median front end, where the rank scan
// tests one candidate per cycle against the n samples of the current window, and
// then through the Kalman back end, whose serial divider finds the gain bit by
// bit; when the gain is exactly zero or one the divider is skipped. A two-entry
// queue of medians lets both halves work on different samples. A stalled result
// holds the back end and, once the queue fills, the input.
module median_kalman_force_filter #(
  parameter int MAX_WINDOW = mkf_pkg::MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] force_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [31:0] median_force, [63:32] filtered_force
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mkf_pkg::*;

  logic [4:0]  window_len_r;
  logic [31:0] process_noise_r;
  logic [31:0] measure_noise_r;
  reg_idx_t    idx;
  logic        cfg_wr;

  med_beat_t   push;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  logic [31:0] q_head;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (idx)
      REG_WINDOW_LEN:    cfg_prdata = {27'd0, window_len_r};
      REG_PROCESS_NOISE: cfg_prdata = process_noise_r;
      REG_MEASURE_NOISE: cfg_prdata = measure_noise_r;
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r    <= WINDOW_LEN_RST;
      process_noise_r <= PROCESS_NOISE_RST;
      measure_noise_r <= MEASURE_NOISE_RST;
    end else if (cfg_wr) begin
      unique case (idx)
        REG_WINDOW_LEN:    window_len_r    <= cfg_pwdata[4:0];
        REG_PROCESS_NOISE: process_noise_r <= cfg_pwdata;
        REG_MEASURE_NOISE: measure_noise_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  mkf_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_sample  (in_tdata),
    .window_len (window_len_r),
    .q_full     (q_full),
    .push       (push)
  );

  mkf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  mkf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .process_noise (process_noise_r),
    .measure_noise (measure_noise_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_data      (out_tdata)
  );

  // The front end is busy scanning in the cycle after each beat.
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("front end took a beat while scanning");

  // The filter only takes a median that the queue holds.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("median queue popped while empty");

  // A median offered to a full queue is held until there is room.
  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && q_full |=> push.valid && $stable(push.median))
    else $error("median dropped at a full queue");

endmodule
